[rtl/core/simon_enc_pkg.sv]
// Shared types, constants and round functions for the Simon 64/96 encryption pipeline.
package simon_enc_pkg;

    localparam int ROUND_COUNT = 42;

    localparam logic [31:0] KS_CONST = 32'hFFFF_FFFC;
    localparam logic [63:0] Z_SEQ    = 64'h7369_F885_192C_0EF5;

    localparam logic [1:0] CFG_KEY_WORD0 = 2'd0;
    localparam logic [1:0] CFG_KEY_WORD1 = 2'd1;
    localparam logic [1:0] CFG_KEY_WORD2 = 2'd2;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
    } stage_data_t;

    function automatic logic [31:0] feistel_f(input logic [31:0] v);
        logic [31:0] rol1;
        logic [31:0] rol2;
        logic [31:0] rol8;
        rol1 = {v[30:0], v[31]};
        rol2 = {v[29:0], v[31:30]};
        rol8 = {v[23:0], v[31:24]};
        return (rol1 & rol8) ^ rol2;
    endfunction

    function automatic logic [31:0] key_word(input logic [31:0] k_back3,
                                             input logic [31:0] k_back1,
                                             input logic        z_bit);
        logic [31:0] ror3;
        logic [31:0] ror4;
        ror3 = {k_back1[2:0], k_back1[31:3]};
        ror4 = {k_back1[3:0], k_back1[31:4]};
        return KS_CONST ^ {31'd0, z_bit} ^ k_back3 ^ ror3 ^ ror4;
    endfunction

endpackage

[rtl/core/simon_enc_stage.sv]
// One pipeline stage: a double Feistel round plus two steps of the key schedule.
module simon_enc_stage #(
    parameter int STAGE = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  simon_enc_pkg::stage_data_t  in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output simon_enc_pkg::stage_data_t  out_data
);

    localparam logic Z_EVEN = simon_enc_pkg::Z_SEQ[2 * STAGE];
    localparam logic Z_ODD  = simon_enc_pkg::Z_SEQ[2 * STAGE + 1];

    logic                       valid_reg;
    logic                       valid_next;
    simon_enc_pkg::stage_data_t data_reg;
    simon_enc_pkg::stage_data_t data_next;
    logic [31:0]                y_mid;
    logic [31:0]                k_new0;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        y_mid        = in_data.y ^ simon_enc_pkg::feistel_f(in_data.x) ^ in_data.k0;
        k_new0       = simon_enc_pkg::key_word(in_data.k0, in_data.k2, Z_EVEN);
        data_next.y  = y_mid;
        data_next.x  = in_data.x ^ simon_enc_pkg::feistel_f(y_mid) ^ in_data.k1;
        data_next.k0 = in_data.k2;
        data_next.k1 = k_new0;
        data_next.k2 = simon_enc_pkg::key_word(in_data.k1, k_new0, Z_ODD);
        valid_next   = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/core/simon_64_96_encrypt.sv]
// Top level of the pipelined Simon 64/96 block encryption core.
//
// Usage:
//   s_axis carries one plaintext block per item (plain_low, plain_high) and
//   m_axis returns its ciphertext block (cipher_low, cipher_high), in order.
//   The cfg channel writes the three key words (index 0 to 2); other indexes
//   are ignored. Write the key only while no block is in flight.
//   Every block runs through ROUND_COUNT/2 = 21 stages, each doing two rounds
//   and two key schedule steps; the block is held in each stage's register in
//   turn before it reaches m_axis. Throughput is one block per cycle as long
//   as the receiver keeps m_axis_tready high.
//   Each stage holds one block with its own valid bit; a stage takes a new
//   block whenever it is empty or its contents move on, so bubbles close up.
//   When the receiver stalls, the output stage holds its block and up to 21
//   blocks are absorbed before s_axis_tready drops.
//   Reset clears all valid bits and sets the key to all zeros.
module simon_64_96_encrypt #(
    parameter int ROUND_COUNT = simon_enc_pkg::ROUND_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] plain_low, [63:32] plain_high
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] cipher_low, [63:32] cipher_high
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int STAGES = ROUND_COUNT / 2;

    logic [31:0]                key_word0_reg;
    logic [31:0]                key_word1_reg;
    logic [31:0]                key_word2_reg;
    logic [STAGES:0]            stage_valid;
    logic [STAGES:0]            stage_ready;
    simon_enc_pkg::stage_data_t stage_data [STAGES+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_word0_reg <= '0;
            key_word1_reg <= '0;
            key_word2_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                simon_enc_pkg::CFG_KEY_WORD0: key_word0_reg <= cfg_data;
                simon_enc_pkg::CFG_KEY_WORD1: key_word1_reg <= cfg_data;
                simon_enc_pkg::CFG_KEY_WORD2: key_word2_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign stage_valid[0]   = s_axis_tvalid;
    assign s_axis_tready    = stage_ready[0];
    assign stage_data[0].x  = s_axis_tdata[31:0];
    assign stage_data[0].y  = s_axis_tdata[63:32];
    assign stage_data[0].k0 = key_word0_reg;
    assign stage_data[0].k1 = key_word1_reg;
    assign stage_data[0].k2 = key_word2_reg;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        simon_enc_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    assign m_axis_tvalid        = stage_valid[STAGES];
    assign stage_ready[STAGES]  = m_axis_tready;
    assign m_axis_tdata         = {stage_data[STAGES].y, stage_data[STAGES].x};

`ifndef SYNTHESIS
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&stage_valid[STAGES:1]))
        else $error("input blocked while a stage is empty");

    a_first_stage_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stage_valid[1]) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("first stage filled without an accepted item");

    for (genvar j = 1; j < STAGES; j++)
    begin : g_chk
        a_advance: assert property (@(posedge clk) disable iff (!rst_n)
            (stage_valid[j] && !stage_valid[j+1]) |=> stage_valid[j+1])
            else $error("item failed to advance into an empty stage");
    end
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the Simon 64/96 encryption core: keys, stalls and back-pressure.
module tb_top;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = 64'd0;   // [31:0] plain_low, [63:32] plain_high
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // [31:0] cipher_low, [63:32] cipher_high
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    logic [63:0] plain_queue[$];
    logic [63:0] cipher_expect[$];
    logic [31:0] key_words[3];
    logic [63:0] want;

    bit          blk_taken = 1'b0;
    bit          gaps_on = 1'b0;
    int unsigned send_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned hold_request = 0;
    int unsigned blocks_in = 0;
    int unsigned blocks_out = 0;
    int unsigned key_settings = 0;
    int unsigned cfg_writes = 0;
    int unsigned fails = 0;
    int unsigned base;

    simon_64_96_encrypt dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] round_mix(input logic [31:0] v);
        return ({v[30:0], v[31]} & {v[23:0], v[31:24]}) ^ {v[29:0], v[31:30]};
    endfunction

    function automatic logic [63:0] simon_encrypt_block(input logic [63:0] blk);
        logic [31:0] rk[simon_enc_pkg::ROUND_COUNT];
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t;
        x = blk[31:0];
        y = blk[63:32];
        rk[0] = key_words[0];
        rk[1] = key_words[1];
        rk[2] = key_words[2];
        for (int i = 3; i < simon_enc_pkg::ROUND_COUNT; i++)
        begin
            t = rk[i-1];
            rk[i] = simon_enc_pkg::KS_CONST ^ {31'd0, simon_enc_pkg::Z_SEQ[i-3]}
                  ^ rk[i-3] ^ {t[2:0], t[31:3]} ^ {t[3:0], t[31:4]};
        end
        for (int i = 0; i + 1 < simon_enc_pkg::ROUND_COUNT; i += 2)
        begin
            y = y ^ round_mix(x) ^ rk[i];
            x = x ^ round_mix(y) ^ rk[i+1];
        end
        return {y, x};
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_random(input int n);
        for (int i = 0; i < n; i++)
            plain_queue.push_back({pick_word(), pick_word()});
    endfunction

    task automatic write_key_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            simon_enc_pkg::CFG_KEY_WORD0: key_words[0] = val;
            simon_enc_pkg::CFG_KEY_WORD1: key_words[1] = val;
            simon_enc_pkg::CFG_KEY_WORD2: key_words[2] = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_key(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2);
        write_key_reg(simon_enc_pkg::CFG_KEY_WORD0, k0);
        write_key_reg(simon_enc_pkg::CFG_KEY_WORD1, k1);
        write_key_reg(simon_enc_pkg::CFG_KEY_WORD2, k2);
        key_settings++;
    endtask

    task automatic wait_drained();
        while (plain_queue.size() != 0 || s_axis_tvalid || cipher_expect.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!s_axis_tvalid || blk_taken)
        begin
            blk_taken = 1'b0;
            if (send_gap != 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (rst_n && plain_queue.size() != 0)
            begin
                s_axis_tdata  <= plain_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                if (gaps_on && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            rx_stall = hold_request;
            hold_request = 0;
        end
        if (rx_stall == 0 && gaps_on && $urandom_range(0, 9) == 0)
            rx_stall = $urandom_range(1, 17);
        if (!rst_n || rx_stall != 0)
        begin
            m_axis_tready <= 1'b0;
            if (rx_stall != 0)
                rx_stall--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cipher_expect.size() == 0)
                begin
                    $error("unexpected item on m_axis: %h", m_axis_tdata);
                    fails++;
                end
                else
                begin
                    want = cipher_expect.pop_front();
                    if (m_axis_tdata[31:0] !== want[31:0])
                    begin
                        $error("cipher_low: expected %h, got %h", want[31:0],
                               m_axis_tdata[31:0]);
                        fails++;
                    end
                    if (m_axis_tdata[63:32] !== want[63:32])
                    begin
                        $error("cipher_high: expected %h, got %h", want[63:32],
                               m_axis_tdata[63:32]);
                        fails++;
                    end
                    blocks_out++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                cipher_expect.push_back(simon_encrypt_block(s_axis_tdata));
                blocks_in++;
                blk_taken = 1'b1;
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        key_words[0] = 32'd0;
        key_words[1] = 32'd0;
        key_words[2] = 32'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        gaps_on = 1'b1;

        plain_queue.push_back(64'h0000_0000_0000_0000);
        plain_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        plain_queue.push_back(64'h0000_0000_FFFF_FFFF);
        plain_queue.push_back(64'hFFFF_FFFF_0000_0000);
        plain_queue.push_back(64'hAAAA_AAAA_5555_5555);
        wait_drained();

        set_key(32'h0302_0100, 32'h0B0A_0908, 32'h1312_1110);
        write_key_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        plain_queue.push_back(64'h6E69_6C63_6F72_2067);
        plain_queue.push_back(64'h0000_0000_0000_0000);
        plain_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        plain_queue.push_back(64'h0000_0000_0000_0000);
        plain_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        plain_queue.push_back(64'h8000_0000_0000_0001);
        plain_queue.push_back(64'h0000_0001_8000_0000);
        wait_drained();

        set_key($urandom, $urandom, $urandom);
        base = blocks_in;
        queue_random(300);
        while (blocks_in < base + 30)
            @(posedge clk);
        hold_request = 100;
        wait_drained();

        set_key(32'd0, 32'd0, 32'd0);
        queue_random(150);
        wait_drained();
        queue_random(150);
        wait_drained();

        set_key(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        write_key_reg(CFG_UNUSED, $urandom);
        queue_random(150);
        wait_drained();

        set_key($urandom, $urandom, $urandom);
        queue_random(200);
        wait_drained();
        write_key_reg(simon_enc_pkg::CFG_KEY_WORD1, $urandom);
        key_settings++;
        queue_random(200);
        wait_drained();

        gaps_on = 1'b0;
        send_gap = 0;
        rx_stall = 0;
        set_key($urandom, $urandom, $urandom);
        queue_random(200);
        wait_drained();
        repeat (30) @(posedge clk);

        if (cipher_expect.size() != 0)
        begin
            $error("%0d ciphertext items never arrived", cipher_expect.size());
            fails++;
        end
        $display("Encrypted %0d blocks, %0d returned, across %0d key settings (%0d writes)",
                 blocks_in, blocks_out, key_settings, cfg_writes);
        $display("Covered zero and all-ones keys, ignored register index, stalls and a full pipe");
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
